[rtl/core/assert_macros.svh]
// Assertion macros shared by the distinct-part partition counter RTL.
// Each macro expands to one labeled concurrent assertion on a clock and an active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

// The expression must never be true.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error(msg);

`endif

[rtl/core/dpc_pkg.sv]
// Package for the distinct-part partition counter: widths, cell count and control types.
// Used by dpc_cell, dpc_ctrl and distinct_partition_count_core; depends on nothing.
`default_nettype none

package dpc_pkg;

	localparam int NMAX      = 512;
	localparam int N_W       = 10;
	localparam int IN_TDATA_W = 16;
	localparam int WAYS_W    = 64;

	// Largest number of distinct parts that a sum up to nmax can hold.
	function automatic int max_parts(input int nmax);
		int k;
		k = 1;
		while (((k + 1) * (k + 2)) / 2 <= nmax) begin
			k = k + 1;
		end
		return k;
	endfunction

	localparam int CELLS = max_parts(NMAX);
	localparam int TAP_W = (CELLS > 1) ? $clog2(CELLS) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_SUM,
		ST_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic clear;
		logic step;
		logic first;
		logic collect;
	} cell_ctl_t;

	typedef struct packed {
		logic load;
		logic bad;
	} fin_t;

endpackage

`default_nettype wire

[rtl/core/dpc_cell.sv]
// One cell of the chain: counts partitions into exactly one fixed number of distinct parts.
// Depends on dpc_pkg; a row of these is built by distinct_partition_count_core.
`default_nettype none

module dpc_cell (
	input  wire logic                      clk,
	input  wire dpc_pkg::cell_ctl_t        ctl,
	input  wire logic [dpc_pkg::TAP_W-1:0] tap,
	input  wire logic [dpc_pkg::WAYS_W-1:0] d_prev,
	input  wire logic [dpc_pkg::WAYS_W-1:0] sum_prev,
	output logic      [dpc_pkg::WAYS_W-1:0] d,
	output logic      [dpc_pkg::WAYS_W-1:0] sum
);
	import dpc_pkg::*;

	logic [WAYS_W-1:0] line_q [CELLS];
	logic [WAYS_W-1:0] sum_q;
	logic [WAYS_W-1:0] u;

	assign d   = line_q[tap];
	assign u   = d + d_prev;
	assign sum = sum_q;

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			for (int j = 0; j < CELLS; j++) begin
				line_q[j] <= '0;
			end
			sum_q <= '0;
		end else if (ctl.step) begin
			line_q[0] <= u;
			for (int j = 1; j < CELLS; j++) begin
				line_q[j] <= line_q[j-1];
			end
		end else if (ctl.collect) begin
			sum_q <= sum_prev + d;
		end
	end

endmodule

`default_nettype wire

[rtl/core/dpc_ctrl.sv]
// Sequencer for the distinct-part partition counter: input handshake, sum steps, final collect.
// Depends on dpc_pkg; drives the cell row and the output register in the top level.
`default_nettype none

module dpc_ctrl (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    s_tvalid,
	output logic                         s_tready,
	input  wire logic [dpc_pkg::N_W-1:0] cube_count,
	input  wire logic                    out_free,
	output dpc_pkg::cell_ctl_t           ctl,
	output dpc_pkg::fin_t                fin
);
	import dpc_pkg::*;

	ctrl_state_t     state_q, state_d;
	logic [N_W-1:0]  cnt_q, cnt_d;
	logic [N_W-1:0]  n_q, n_d;
	logic            bad_q, bad_d;
	logic            bad_in;

	assign bad_in = (cube_count == '0) || (cube_count > N_W'(NMAX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		n_q   <= n_d;
		bad_q <= bad_d;
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		n_d      = n_q;
		bad_d    = bad_q;
		ctl      = '0;
		fin      = '0;
		fin.bad  = bad_q;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					ctl.clear = 1'b1;
					n_d       = cube_count;
					bad_d     = bad_in;
					cnt_d     = '0;
					state_d   = bad_in ? ST_DONE : ST_RUN;
				end
			end
			ST_RUN: begin
				ctl.step  = 1'b1;
				ctl.first = (cnt_q == '0);
				if (cnt_q == n_q - N_W'(1)) begin
					cnt_d   = '0;
					state_d = ST_SUM;
				end else begin
					cnt_d = cnt_q + N_W'(1);
				end
			end
			ST_SUM: begin
				ctl.collect = 1'b1;
				if (cnt_q == N_W'(CELLS - 1)) begin
					cnt_d   = '0;
					state_d = ST_DONE;
				end else begin
					cnt_d = cnt_q + N_W'(1);
				end
			end
			ST_DONE: begin
				if (out_free) begin
					fin.load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

[rtl/core/distinct_partition_count_core.sv]
// Top level of the distinct-part partition counter: sequencer, row of cells, output register.
// Depends on dpc_pkg, dpc_cell, dpc_ctrl and assert_macros.svh.
//
// Channel  Dir  Beat fields
// s_*      in   tdata[9:0] cube_count
// m_*      out  tdata[63:0] ways, tuser bad_request
//
// A request n in range passes through ST_RUN, ST_SUM and ST_DONE on its way from beat to result.
// The cells step once per sum value from 0 to n-1, then a collect wave runs down the row.
// A rejected request goes from its beat straight to ST_DONE, skipping ST_RUN and ST_SUM.
// The next beat is taken as soon as the result reaches the output register.
// Reset clears state, counter and m_tvalid only; the cells are cleared on every accepted beat.
`default_nettype none
`include "assert_macros.svh"

module distinct_partition_count_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [dpc_pkg::IN_TDATA_W-1:0] s_tdata,  // [9:0] cube_count
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic      [dpc_pkg::WAYS_W-1:0]     m_tdata,  // [63:0] ways
	output logic                                m_tuser   // [0] bad_request
);
	import dpc_pkg::*;

	cell_ctl_t         ctl;
	fin_t              fin;
	logic              out_free;
	logic              m_tvalid_q;
	logic [WAYS_W-1:0] m_tdata_q;
	logic              m_tuser_q;
	logic [WAYS_W-1:0] d_w   [CELLS+1];
	logic [WAYS_W-1:0] sum_w [CELLS+1];

	assign out_free = !m_tvalid_q || m_tready;

	dpc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.cube_count (s_tdata[N_W-1:0]),
		.out_free   (out_free),
		.ctl        (ctl),
		.fin        (fin)
	);

	assign d_w[0]   = WAYS_W'(ctl.first);
	assign sum_w[0] = '0;

	for (genvar k = 1; k <= CELLS; k++) begin : g_cell
		dpc_cell u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.tap      (TAP_W'(k - 1)),
			.d_prev   (d_w[k-1]),
			.sum_prev (sum_w[k-1]),
			.d        (d_w[k]),
			.sum      (sum_w[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (fin.load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin.load) begin
			m_tdata_q <= fin.bad ? '0 : sum_w[CELLS];
			m_tuser_q <= fin.bad;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	`ASSERT_NEXT(a_busy_after_beat, clk, arst_n, s_tvalid && s_tready, !s_tready, "input taken while busy")
	`ASSERT_SAME(a_bad_zero, clk, arst_n, m_tvalid && m_tuser, m_tdata == '0, "rejected beat with nonzero count")
	`ASSERT_NEVER(a_step_collect, clk, arst_n, ctl.step && ctl.collect, "cells stepped and collected together")

endmodule

`default_nettype wire
